// File: rtl/xxh32_pkg.sv
// xxh32_pkg: types and constants shared by the streaming XXH32 block.
// No dependencies.
package xxh32_pkg;

	localparam logic [31:0] PRIME1 = 32'd2654435761;
	localparam logic [31:0] PRIME2 = 32'd2246822519;
	localparam logic [31:0] PRIME3 = 32'd3266489917;
	localparam logic [31:0] PRIME4 = 32'd668265263;
	localparam logic [31:0] PRIME5 = 32'd374761393;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_STORE,     // store byte, count length
		OP_LANE_INIT, // load lanes from seed
		OP_LANE_MUL1, // t = word * P2
		OP_LANE_MUL2, // t = rol(acc + t, 13) * P1, write lane
		OP_CONV,      // h = converge or seed + P5, plus length
		OP_WORD_MUL1, // t = word * P3
		OP_WORD_MUL2, // h = rol(h + t, 17) * P4
		OP_BYTE_MUL1, // t = byte * P5
		OP_BYTE_MUL2, // h = rol(h + t, 11) * P1
		OP_AV1,       // h = (h ^ h>>15) * P2
		OP_AV2,       // h = (h ^ h>>13) * P3
		OP_AV3,       // h = h ^ h>>16, load result
		OP_CLEAR      // end of message
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LANE,
		ST_FIN,
		ST_TAIL,
		ST_AV,
		ST_OUT
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] lane;  // lane index / word index
		logic [3:0] pos;   // byte position of tail
	} cmd_t;

	typedef struct packed {
		logic [4:0] fill;
		logic       seen;
	} status_t;

endpackage

// File: rtl/xxhash32_stream.sv
// xxhash32_stream: top level of the streaming XXH32 hasher.
// Depends on xxh32_pkg, xxh32_ctrl, xxh32_datapath.
// Takes one beat at a time. A plain byte is only stored. A byte that fills a
// 16-byte stripe starts lane work, two multiplies per lane on the one shared 32x32
// multiplier, after a lane load on the first stripe of a message. On last, finish
// runs converge, then MUL1 and MUL2 per tail word and per tail byte, then AV1 to AV3,
// and the hash is held until taken. No intake meanwhile.
module xxhash32_stream (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        byte_valid,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash_value
);

	logic [31:0] seed_q;
	xxh32_pkg::cmd_t    cmd;
	xxh32_pkg::status_t status;

	// seed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seed_q <= '0;
		else if (cfg_we) seed_q <= cfg_wdata;
	end

	xxh32_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .byte_valid, .last,
		.out_valid, .out_ready, .status, .cmd
	);

	xxh32_datapath u_dp (
		.clk, .arst_n, .seed(seed_q), .data_byte, .cmd, .status, .hash_q(hash_value)
	);

endmodule

// File: rtl/xxh32_datapath.sv
// xxh32_datapath: lanes, stripe buffer, length, hash register, one shared multiplier.
// Depends on xxh32_pkg.
module xxh32_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         seed,
	input  logic [7:0]          data_byte,
	input  xxh32_pkg::cmd_t     cmd,
	output xxh32_pkg::status_t  status,
	output logic [31:0]         hash_q
);

	logic [7:0]  buf_q [16];
	logic [31:0] lane_q [4];
	logic [31:0] len_q;
	logic [31:0] t_q;
	logic [4:0]  fill_q;
	logic        seen_q;

	logic [31:0] word, mul_a, mul_b, mul_p, sum;
	logic [3:0]  wbase;

	assign wbase = {cmd.lane, 2'b00};
	assign word  = {buf_q[wbase + 4'd3], buf_q[wbase + 4'd2],
		buf_q[wbase + 4'd1], buf_q[wbase]};

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		sum   = '0;
		case (cmd.op)
			xxh32_pkg::OP_LANE_MUL1: begin mul_a = word; mul_b = xxh32_pkg::PRIME2; end
			xxh32_pkg::OP_LANE_MUL2: begin
				sum = lane_q[cmd.lane] + t_q;
				mul_a = {sum[18:0], sum[31:19]}; mul_b = xxh32_pkg::PRIME1;
			end
			xxh32_pkg::OP_WORD_MUL1: begin mul_a = word; mul_b = xxh32_pkg::PRIME3; end
			xxh32_pkg::OP_WORD_MUL2: begin
				sum = hash_q + t_q;
				mul_a = {sum[14:0], sum[31:15]}; mul_b = xxh32_pkg::PRIME4;
			end
			xxh32_pkg::OP_BYTE_MUL1: begin
				mul_a = {24'd0, buf_q[cmd.pos]}; mul_b = xxh32_pkg::PRIME5;
			end
			xxh32_pkg::OP_BYTE_MUL2: begin
				sum = hash_q + t_q;
				mul_a = {sum[20:0], sum[31:21]}; mul_b = xxh32_pkg::PRIME1;
			end
			xxh32_pkg::OP_AV1: begin
				mul_a = hash_q ^ (hash_q >> 15); mul_b = xxh32_pkg::PRIME2;
			end
			xxh32_pkg::OP_AV2: begin
				mul_a = hash_q ^ (hash_q >> 13); mul_b = xxh32_pkg::PRIME3;
			end
			default: ;
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// control state: fill count, length, stripe flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			len_q  <= '0;
			seen_q <= 1'b0;
		end else begin
			case (cmd.op)
				xxh32_pkg::OP_STORE: begin
					fill_q <= (fill_q == 5'd15) ? 5'd0 : fill_q + 5'd1;
					len_q  <= len_q + 32'd1;
				end
				xxh32_pkg::OP_LANE_INIT: seen_q <= 1'b1;
				xxh32_pkg::OP_CLEAR: begin
					fill_q <= '0;
					len_q  <= '0;
					seen_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			xxh32_pkg::OP_STORE: buf_q[fill_q[3:0]] <= data_byte;
			xxh32_pkg::OP_LANE_INIT: begin
				lane_q[0] <= seed + xxh32_pkg::PRIME1 + xxh32_pkg::PRIME2;
				lane_q[1] <= seed + xxh32_pkg::PRIME2;
				lane_q[2] <= seed;
				lane_q[3] <= seed - xxh32_pkg::PRIME1;
			end
			xxh32_pkg::OP_LANE_MUL1, xxh32_pkg::OP_WORD_MUL1,
			xxh32_pkg::OP_BYTE_MUL1: t_q <= mul_p;
			xxh32_pkg::OP_LANE_MUL2: lane_q[cmd.lane] <= mul_p;
			xxh32_pkg::OP_CONV: begin
				if (seen_q)
					hash_q <= {lane_q[0][30:0], lane_q[0][31]}
						+ {lane_q[1][24:0], lane_q[1][31:25]}
						+ {lane_q[2][19:0], lane_q[2][31:20]}
						+ {lane_q[3][13:0], lane_q[3][31:14]} + len_q;
				else
					hash_q <= seed + xxh32_pkg::PRIME5 + len_q;
			end
			xxh32_pkg::OP_WORD_MUL2, xxh32_pkg::OP_BYTE_MUL2,
			xxh32_pkg::OP_AV1, xxh32_pkg::OP_AV2: hash_q <= mul_p;
			xxh32_pkg::OP_AV3: hash_q <= hash_q ^ (hash_q >> 16);
			default: ;
		endcase
	end

	assign status = '{fill: fill_q, seen: seen_q};

endmodule

// File: rtl/xxh32_ctrl.sv
// xxh32_ctrl: sequencer for byte intake, stripe rounds, finish and output.
// Depends on xxh32_pkg.
module xxh32_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                byte_valid,
	input  logic                last,
	output logic                out_valid,
	input  logic                out_ready,
	input  xxh32_pkg::status_t  status,
	output xxh32_pkg::cmd_t     cmd
);

	xxh32_pkg::state_t state_q, state_d;
	logic [1:0] lane_q, lane_d;
	logic       ph_q, ph_d;     // multiply phase
	logic [3:0] pos_q, pos_d;   // tail byte position
	logic       last_q, last_d;
	logic       acc;

	assign acc = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xxh32_pkg::ST_IDLE;
			lane_q  <= '0;
			ph_q    <= 1'b0;
			pos_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			lane_q  <= lane_d;
			ph_q    <= ph_d;
			pos_q   <= pos_d;
			last_q  <= last_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		lane_d    = lane_q;
		ph_d      = ph_q;
		pos_d     = pos_q;
		last_d    = last_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '{op: xxh32_pkg::OP_NONE, lane: lane_q, pos: pos_q};
		unique case (state_q)
			xxh32_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (acc) begin
					last_d = last;
					lane_d = '0;
					ph_d   = 1'b0;
					if (byte_valid) begin
						cmd.op = xxh32_pkg::OP_STORE;
						if (status.fill == 5'd15) state_d = xxh32_pkg::ST_LANE;
						else if (last) state_d = xxh32_pkg::ST_FIN;
					end else if (last) state_d = xxh32_pkg::ST_FIN;
				end
			end
			xxh32_pkg::ST_LANE: begin
				if (!status.seen) cmd.op = xxh32_pkg::OP_LANE_INIT;
				else begin
					cmd.op = ph_q ? xxh32_pkg::OP_LANE_MUL2 : xxh32_pkg::OP_LANE_MUL1;
					ph_d = !ph_q;
					if (ph_q) begin
						lane_d = lane_q + 2'd1;
						if (lane_q == 2'd3)
							state_d = last_q ? xxh32_pkg::ST_FIN : xxh32_pkg::ST_IDLE;
					end
				end
			end
			xxh32_pkg::ST_FIN: begin
				cmd.op  = xxh32_pkg::OP_CONV;
				pos_d   = '0;
				ph_d    = 1'b0;
				state_d = xxh32_pkg::ST_TAIL;
			end
			xxh32_pkg::ST_TAIL: begin
				cmd.lane = pos_q[3:2];
				if ({1'b0, pos_q} + 5'd4 <= status.fill) begin
					cmd.op = ph_q ? xxh32_pkg::OP_WORD_MUL2 : xxh32_pkg::OP_WORD_MUL1;
					ph_d = !ph_q;
					if (ph_q) pos_d = pos_q + 4'd4;
				end else if ({1'b0, pos_q} < status.fill) begin
					cmd.op = ph_q ? xxh32_pkg::OP_BYTE_MUL2 : xxh32_pkg::OP_BYTE_MUL1;
					ph_d = !ph_q;
					if (ph_q) pos_d = pos_q + 4'd1;
				end else begin
					lane_d  = '0;
					state_d = xxh32_pkg::ST_AV;
				end
			end
			xxh32_pkg::ST_AV: begin
				unique case (lane_q)
					2'd0: cmd.op = xxh32_pkg::OP_AV1;
					2'd1: cmd.op = xxh32_pkg::OP_AV2;
					default: begin
						cmd.op  = xxh32_pkg::OP_AV3;
						state_d = xxh32_pkg::ST_OUT;
					end
				endcase
				cmd.lane = lane_q;
				lane_d = lane_q + 2'd1;
			end
			xxh32_pkg::ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.op  = xxh32_pkg::OP_CLEAR;
					state_d = xxh32_pkg::ST_IDLE;
				end
			end
			default: state_d = xxh32_pkg::ST_IDLE;
		endcase
	end

	// no intake while a result is pending
	a_no_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready with result pending");
	// a full stripe always starts lane work
	a_stripe: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && byte_valid && status.fill == 5'd15) |=> state_q == xxh32_pkg::ST_LANE)
		else $error("stripe not processed");
	// fill stays below a stripe
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		status.fill < 5'd16) else $error("fill overflow");

endmodule

// File: tb/sv/tb_top.sv
// tb_top: self-checking testbench for xxhash32_stream (streaming XXH32, seeded).
// Depends on xxh32_pkg and the xxhash32_stream RTL; predicts hashes internally.
`timescale 1ns / 100ps

module tb_top;

	localparam int LIMIT_CYCLES = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = '0;
	logic        byte_valid = 1'b0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] hash_value;

	xxhash32_stream u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
		.byte_valid(byte_valid), .last(last), .out_valid(out_valid),
		.out_ready(out_ready), .hash_value(hash_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predictor state
	logic [31:0] cur_seed;
	logic [31:0] lanes [4];
	logic [7:0]  stripe [16];
	int unsigned fill;
	logic [31:0] msg_len;
	bit          seen;
	logic [31:0] hash_q [$];
	int          errors = 0;
	int          cycles = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	bit          hold_off = 1'b0;

	function automatic logic [31:0] rol(logic [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] word_at(int at);
		return {stripe[at + 3], stripe[at + 2], stripe[at + 1], stripe[at]};
	endfunction

	// advance the model by one beat, queue the hash on last
	task automatic hash_model_step(logic [7:0] b, logic bv, logic lst);
		logic [31:0] h;
		int at;
		if (bv) begin
			stripe[fill] = b;
			fill++;
			msg_len++;
			if (fill == 16) begin
				if (!seen) begin
					lanes[0] = cur_seed + xxh32_pkg::PRIME1 + xxh32_pkg::PRIME2;
					lanes[1] = cur_seed + xxh32_pkg::PRIME2;
					lanes[2] = cur_seed;
					lanes[3] = cur_seed - xxh32_pkg::PRIME1;
					seen = 1'b1;
				end
				for (int k = 0; k < 4; k++)
					lanes[k] = rol(lanes[k] + word_at(4 * k) * xxh32_pkg::PRIME2, 13)
						* xxh32_pkg::PRIME1;
				fill = 0;
			end
		end
		if (lst) begin
			if (seen)
				h = rol(lanes[0], 1) + rol(lanes[1], 7) + rol(lanes[2], 12)
					+ rol(lanes[3], 18);
			else
				h = cur_seed + xxh32_pkg::PRIME5;
			h += msg_len;
			at = 0;
			while (at + 4 <= fill) begin
				h = rol(h + word_at(at) * xxh32_pkg::PRIME3, 17) * xxh32_pkg::PRIME4;
				at += 4;
			end
			while (at < fill) begin
				h = rol(h + stripe[at] * xxh32_pkg::PRIME5, 11) * xxh32_pkg::PRIME1;
				at++;
			end
			h ^= h >> 15;
			h *= xxh32_pkg::PRIME2;
			h ^= h >> 13;
			h *= xxh32_pkg::PRIME3;
			h ^= h >> 16;
			hash_q.push_back(h);
			fill = 0;
			msg_len = 0;
			seen = 1'b0;
		end
	endtask

	// send one beat, honoring the idle rate; hold valid until accepted
	task automatic send_beat(logic [7:0] b, logic bv, logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		byte_valid <= bv;
		last <= lst;
		hash_model_step(b, bv, lst);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_message(int len, bit noise);
		for (int i = 0; i < len; i++) begin
			if (noise && $urandom_range(9) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(8'($urandom), 1'b1, (i == len - 1) ? 1'b1 : 1'b0);
		end
		if (len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic drain_and_write_seed(logic [31:0] s);
		in_valid <= 1'b0;
		while (hash_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= s;
		cur_seed = s;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// receiver: random stalls plus a long hold-off window
	always @(posedge clk) begin
		out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (hash_q.size() == 0) begin
				$error("hash_value: unexpected beat, actual %h", hash_value);
				errors++;
			end else begin
				if (hash_value !== hash_q[0]) begin
					$error("hash_value: expected %h actual %h", hash_q[0], hash_value);
					errors++;
				end
				void'(hash_q.pop_front());
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("xxhash32_stream verification failed");
			$finish;
		end
	end

	typedef struct {
		logic [7:0]  b;
		logic        bv;
		logic        lst;
		bit          known;
		logic [31:0] hash;
	} dir_row_t;

	dir_row_t dir_rows [] = '{
		// empty message, seed 0: the well-known empty hash
		'{8'h00, 1'b0, 1'b1, 1'b1, 32'h02CC5D05},
		// no-byte no-last beat does nothing
		'{8'hA5, 1'b0, 1'b0, 1'b0, 32'h0},
		'{8'h00, 1'b1, 1'b1, 1'b0, 32'h0},
		'{8'hFF, 1'b1, 1'b1, 1'b0, 32'h0},
		'{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
		'{8'h00, 1'b0, 1'b1, 1'b0, 32'h0},
		'{8'h01, 1'b1, 1'b0, 1'b0, 32'h0},
		'{8'h02, 1'b1, 1'b0, 1'b0, 32'h0},
		'{8'h03, 1'b1, 1'b0, 1'b0, 32'h0},
		'{8'h04, 1'b1, 1'b0, 1'b0, 32'h0},
		'{8'h55, 1'b0, 1'b0, 1'b0, 32'h0},
		'{8'hAA, 1'b1, 1'b1, 1'b0, 32'h0}
	};

	initial begin
		cur_seed = '0;
		fill = 0;
		msg_len = '0;
		seen = 1'b0;
		for (int k = 0; k < 4; k++) lanes[k] = '0;
		for (int k = 0; k < 16; k++) stripe[k] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (dir_rows[i]) begin
			send_beat(dir_rows[i].b, dir_rows[i].bv, dir_rows[i].lst);
			if (dir_rows[i].known && hash_q[$] !== dir_rows[i].hash) begin
				$error("hash_value: expected %h actual %h", dir_rows[i].hash, hash_q[$]);
				errors++;
			end
		end
		// exactly one stripe, the empty message with an all-ones seed, and stripe plus a tail word and bytes
		send_message(16, 1'b0);
		drain_and_write_seed(32'hFFFF_FFFF);
		send_beat(8'h00, 1'b0, 1'b1);
		send_message(16 + 7, 1'b0);
		// seed change mid-message short path: bytes now, seed later
		send_beat(8'h11, 1'b1, 1'b0);
		drain_and_write_seed(32'h0000_0000);
		send_beat(8'h22, 1'b1, 1'b1);

		// random phases: idle rates and seeds vary
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 53; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 53; end
				3: begin send_idle_pct = 24; recv_stall_pct = 24; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			drain_and_write_seed((ph == 4) ? 32'h0 : $urandom);
			if (ph == 4) begin
				// long receiver hold-off while beats keep coming
				fork
					begin
						hold_off = 1'b1;
						repeat (400) @(posedge clk);
						hold_off = 1'b0;
					end
				join_none
			end
			for (int m = 0; m < 18; m++) begin
				case ($urandom_range(9))
					0: send_message(0, 1'b0);
					1: send_message($urandom_range(33, 64), 1'b1);
					default: send_message($urandom_range(1, 20), 1'b1);
				endcase
			end
		end

		in_valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (hash_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("xxhash32_stream verification clean");
		else
			$display("xxhash32_stream verification failed");
		$finish;
	end
endmodule
